[rtl/core/bhpid_pkg.sv]
// constants, control word types and microcode program for the ball-height pid controller
package bhpid_pkg;

    // port widths
    localparam int ADC_W      = 16;
    localparam int ECHO_W     = 16;
    localparam int DRIVE_W    = 10;
    localparam int TOTAL_W    = 32;
    localparam int SETPOINT_W = 15;
    localparam int MEAS_W     = 17;
    localparam int GAIN_W     = 32;
    localparam int TICK_W     = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS    = CFG_IDX_W'(3);

    // configuration reset values
    localparam logic [GAIN_W-1:0] RST_GAIN_PROP  = GAIN_W'(327680);
    localparam logic [GAIN_W-1:0] RST_GAIN_INTEG = GAIN_W'(66);
    localparam logic [GAIN_W-1:0] RST_GAIN_DERIV = GAIN_W'(131072);
    localparam logic [TICK_W-1:0] RST_TICK_MS    = TICK_W'(25);

    // plant constants
    localparam int ECHO_LIMIT_US = 18500;
    localparam int DRIVE_MAX     = 1023;
    localparam int DRIVE_LIM     = (DRIVE_MAX < 1023) ? DRIVE_MAX : 1023;
    localparam int CODE_W        = 12;
    localparam int CODE_CUTOFF   = 1800;
    localparam int SP_SCALE      = 25600;
    localparam int SP_DIV        = 1742;
    localparam int MS_SCALE      = 544;
    localparam int MS_DIV        = 125;
    localparam int SET_MIN       = 1280;
    localparam int SET_MAX       = 23040;
    localparam int MEAS_SAT      = 131071;

    // datapath widths
    localparam int NUM_W     = 26;   // scaled code or echo before the constant division
    localparam int Q_W       = 19;   // quotient of a constant division
    localparam int RCP_SHIFT = 32;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 62;
    localparam int GAIN_FRAC = 16;
    localparam int ERR_W     = 18;
    localparam int DIFF_W    = 19;
    localparam int ET_W      = 28;   // error times interval
    localparam int ACC_W     = 40;
    localparam int DIV_W     = 36;   // magnitude of the derivative dividend
    localparam int DIV_STEP  = 4;    // quotient bits per cycle
    localparam int DIV_ITERS = DIV_W / DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS + 1);
    localparam int DQ_W      = DIV_W + 2;

    // reciprocals for the constant divisions, corrected by one compare afterwards
    localparam logic [MUL_W-1:0] SP_RCP = MUL_W'((64'd1 << RCP_SHIFT) / SP_DIV);
    localparam logic [MUL_W-1:0] MS_RCP = MUL_W'((64'd1 << RCP_SHIFT) / MS_DIV);

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP         = 4'd0,
        OP_LOAD        = 4'd1,
        OP_MUL_SP_RCP  = 4'd2,
        OP_MUL_SP_BACK = 4'd3,
        OP_SP_FIX      = 4'd4,
        OP_MUL_MS_RCP  = 4'd5,
        OP_MUL_MS_BACK = 4'd6,
        OP_MS_FIX      = 4'd7,
        OP_ERR         = 4'd8,
        OP_MUL_P       = 4'd9,
        OP_P_ACC       = 4'd10,
        OP_MUL_I       = 4'd11,
        OP_INTEG       = 4'd12,
        OP_D_START     = 4'd13,
        OP_FINISH      = 4'd14
    } op_t;

    // wait conditions: the step repeats while its condition holds
    typedef enum logic [1:0] {
        HOLD_NONE = 2'd0,
        HOLD_IN   = 2'd1,
        HOLD_DIV  = 2'd2,
        HOLD_OUT  = 2'd3
    } hold_t;

    localparam int NUM_STEPS = 15;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    localparam logic [STEP_W-1:0] STEP_LOAD = STEP_W'(0);

    typedef struct packed {
        op_t               op;
        hold_t             hold;
        logic              jump;
        logic [STEP_W-1:0] target;
    } ctl_word_t;

    // control program, one word per step
    localparam ctl_word_t PROGRAM [NUM_STEPS] = '{
        '{OP_LOAD,        HOLD_IN,   1'b0, STEP_LOAD},
        '{OP_MUL_SP_RCP,  HOLD_NONE, 1'b0, STEP_LOAD},
        '{OP_MUL_SP_BACK, HOLD_NONE, 1'b0, STEP_LOAD},
        '{OP_SP_FIX,      HOLD_NONE, 1'b0, STEP_LOAD},
        '{OP_MUL_MS_RCP,  HOLD_NONE, 1'b0, STEP_LOAD},
        '{OP_MUL_MS_BACK, HOLD_NONE, 1'b0, STEP_LOAD},
        '{OP_MS_FIX,      HOLD_NONE, 1'b0, STEP_LOAD},
        '{OP_ERR,         HOLD_NONE, 1'b0, STEP_LOAD},
        '{OP_MUL_P,       HOLD_NONE, 1'b0, STEP_LOAD},
        '{OP_P_ACC,       HOLD_NONE, 1'b0, STEP_LOAD},
        '{OP_MUL_I,       HOLD_NONE, 1'b0, STEP_LOAD},
        '{OP_INTEG,       HOLD_NONE, 1'b0, STEP_LOAD},
        '{OP_D_START,     HOLD_NONE, 1'b0, STEP_LOAD},
        '{OP_NOP,         HOLD_DIV,  1'b0, STEP_LOAD},
        '{OP_FINISH,      HOLD_OUT,  1'b1, STEP_LOAD}
    };

endpackage

[rtl/core/ball_height_pid_controller.sv]
// Ball-height PID controller: one control tick per input item (converter word and echo width)
// gives one result item (fan drive, PID total, setpoint and measured height, Q.8 cm).
// Control is a 15-step microprogram around one 33x33 signed multiplier and a 4-bit-per-cycle
// divider for the derivative term. Each item uses the multiplier in turn for the setpoint and
// height scaling by reciprocal and for the P, I and D products, then waits for the divider;
// its result is then registered, and no new item is taken before that.
// The result sits in an output register, so the next item is taken while it waits; the program
// stalls only in its last step if the previous result has still not been taken.
// Gains and the interval are to be written over the cfg channel while no item is in flight;
// the block does not enforce it. cfg_ready is always high; writes above index 3 are ignored.
module ball_height_pid_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bhpid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bhpid_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bhpid_pkg::ADC_W-1:0]         s_adc_word,
    input  logic [bhpid_pkg::ECHO_W-1:0]        s_echo_us,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bhpid_pkg::DRIVE_W-1:0]       m_drive,
    output logic signed [bhpid_pkg::TOTAL_W-1:0] m_pid_total,
    output logic [bhpid_pkg::SETPOINT_W-1:0]    m_setpoint_cm,
    output logic [bhpid_pkg::MEAS_W-1:0]        m_measured_cm
);
    import bhpid_pkg::*;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [TOTAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-TOTAL_W:0] hi;
        hi = v[PROD_W-1:TOTAL_W-1];
        if (&hi || ~|hi) begin
            return v[TOTAL_W-1:0];
        end else if (v[PROD_W-1]) begin
            return {1'b1, {(TOTAL_W-1){1'b0}}};
        end else begin
            return {1'b0, {(TOTAL_W-1){1'b1}}};
        end
    endfunction

    // configuration registers
    logic [GAIN_W-1:0] gain_prop_reg;
    logic [GAIN_W-1:0] gain_integ_reg;
    logic [GAIN_W-1:0] gain_deriv_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [TICK_W-1:0] tick_eff;

    // sequencer
    logic [STEP_W-1:0] step_reg, step_next;
    ctl_word_t         ctl;
    logic              hold;

    // datapath registers
    logic [NUM_W-1:0]             sp_num_reg, sp_num_next;
    logic [NUM_W-1:0]             ms_num_reg, ms_num_next;
    logic [Q_W-1:0]               q_reg, q_next;
    logic signed [PROD_W-1:0]     prod_reg, prod_next;
    logic [SETPOINT_W-1:0]        sp_reg, sp_next;
    logic [MEAS_W-1:0]            meas_reg, meas_next;
    logic signed [ERR_W-1:0]      err_reg, err_next;
    logic signed [DIFF_W-1:0]     diff_reg, diff_next;
    logic signed [ERR_W-1:0]      last_err_reg, last_err_next;
    logic signed [TOTAL_W-1:0]    integral_reg, integral_next;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;

    // divider registers
    logic [DIV_W-1:0]             dv_quo_reg, dv_quo_next, dv_quo_step;
    logic [TICK_W-1:0]            dv_rem_reg, dv_rem_next, dv_rem_step;
    logic [DIV_CNT_W-1:0]         dv_cnt_reg, dv_cnt_next;
    logic                         dv_neg_reg, dv_neg_next;

    // output register
    logic                         m_valid_reg, m_valid_next;
    logic [DRIVE_W-1:0]           out_drive_reg, out_drive_next;
    logic signed [TOTAL_W-1:0]    out_total_reg, out_total_next;
    logic [SETPOINT_W-1:0]        out_sp_reg, out_sp_next;
    logic [MEAS_W-1:0]            out_meas_reg, out_meas_next;

    // combinational terms
    logic [CODE_W-1:0]            code_raw, code_cut;
    logic [ECHO_W-1:0]            echo_sat;
    logic signed [MUL_W-1:0]      mul_a, mul_b;
    logic signed [2*MUL_W-1:0]    mul_full;
    logic [NUM_W-1:0]             sp_rem, ms_rem;
    logic [Q_W-1:0]               sp_q, ms_q;
    logic [SETPOINT_W-1:0]        sp_clamped;
    logic [MEAS_W-1:0]            meas_sat;
    logic signed [ERR_W-1:0]      err_val;
    logic signed [DIFF_W-1:0]     diff_val;
    logic signed [ET_W-1:0]       et_val;
    logic signed [PROD_W-1:0]     integ_sum;
    logic signed [DIV_W:0]        div_pre;
    logic [DIV_W-1:0]             div_mag;
    logic signed [DQ_W-1:0]       dq;
    logic signed [PROD_W-1:0]     total_sum;
    logic signed [TOTAL_W-1:0]    total_sat;
    logic [TOTAL_W-10:0]          total_whole;
    logic [DRIVE_W-1:0]           drive_val;

    assign cfg_ready = 1'b1;
    assign tick_eff  = (tick_reg == '0) ? TICK_W'(1) : tick_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg  <= RST_GAIN_PROP;
            gain_integ_reg <= RST_GAIN_INTEG;
            gain_deriv_reg <= RST_GAIN_DERIV;
            tick_reg       <= RST_TICK_MS;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GAIN_PROP:  gain_prop_reg  <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_INTEG: gain_integ_reg <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_DERIV: gain_deriv_reg <= cfg_data[GAIN_W-1:0];
                CFG_TICK_MS:    tick_reg       <= cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // current control word and its wait condition
    assign ctl = PROGRAM[step_reg];

    always_comb begin
        case (ctl.hold)
            HOLD_NONE: hold = 1'b0;
            HOLD_IN:   hold = !s_valid;
            HOLD_DIV:  hold = (dv_cnt_reg != '0);
            HOLD_OUT:  hold = m_valid_reg && !m_ready;
            default:   hold = 1'b0;
        endcase
    end

    assign s_ready = (ctl.op == OP_LOAD);

    // input decode: byte swap, 12-bit code, cutoff, echo saturation
    assign code_raw = {s_adc_word[7:0], s_adc_word[15:12]};
    assign code_cut = (code_raw > CODE_W'(CODE_CUTOFF)) ? '0 : code_raw;
    assign echo_sat = (s_echo_us < ECHO_W'(ECHO_LIMIT_US)) ? s_echo_us : ECHO_W'(ECHO_LIMIT_US);

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctl.op)
            OP_MUL_SP_RCP: begin
                mul_a = $signed(MUL_W'(sp_num_reg));
                mul_b = $signed(SP_RCP);
            end
            OP_MUL_SP_BACK: begin
                mul_a = $signed(MUL_W'(prod_reg[RCP_SHIFT +: Q_W]));
                mul_b = $signed(MUL_W'(SP_DIV));
            end
            OP_MUL_MS_RCP: begin
                mul_a = $signed(MUL_W'(ms_num_reg));
                mul_b = $signed(MS_RCP);
            end
            OP_MUL_MS_BACK: begin
                mul_a = $signed(MUL_W'(prod_reg[RCP_SHIFT +: Q_W]));
                mul_b = $signed(MUL_W'(MS_DIV));
            end
            OP_MUL_P: begin
                mul_a = $signed(MUL_W'(gain_prop_reg));
                mul_b = MUL_W'(err_reg);
            end
            OP_P_ACC: begin
                mul_a = MUL_W'(err_reg);
                mul_b = $signed(MUL_W'(tick_eff));
            end
            OP_MUL_I: begin
                mul_a = $signed(MUL_W'(gain_integ_reg));
                mul_b = MUL_W'(et_val);
            end
            OP_INTEG: begin
                mul_a = $signed(MUL_W'(gain_deriv_reg));
                mul_b = MUL_W'(diff_reg);
            end
            default: ;
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // reciprocal correction for setpoint and height
    assign sp_rem = sp_num_reg - prod_reg[NUM_W-1:0];
    assign sp_q   = q_reg + Q_W'(sp_rem >= NUM_W'(SP_DIV));
    assign sp_clamped = (sp_q < Q_W'(SET_MIN)) ? SETPOINT_W'(SET_MIN) :
                        (sp_q > Q_W'(SET_MAX)) ? SETPOINT_W'(SET_MAX) : sp_q[SETPOINT_W-1:0];

    assign ms_rem   = ms_num_reg - prod_reg[NUM_W-1:0];
    assign ms_q     = q_reg + Q_W'(ms_rem >= NUM_W'(MS_DIV));
    assign meas_sat = (ms_q > Q_W'(MEAS_SAT)) ? MEAS_W'(MEAS_SAT) : ms_q[MEAS_W-1:0];

    // error terms and integral
    assign err_val   = $signed(ERR_W'(sp_reg)) - $signed(ERR_W'(meas_reg));
    assign diff_val  = DIFF_W'(err_val) - DIFF_W'(last_err_reg);
    assign et_val    = $signed(prod_reg[ET_W-1:0]);
    assign integ_sum = PROD_W'(integral_reg) + (prod_reg >>> GAIN_FRAC);

    // derivative dividend split into sign and magnitude
    assign div_pre = $signed(prod_reg[GAIN_FRAC +: DIV_W+1]);
    assign div_mag = div_pre[DIV_W] ? DIV_W'(-div_pre) : DIV_W'(div_pre);

    // divider: DIV_STEP restoring steps per cycle on a narrow remainder
    always_comb begin
        logic [TICK_W:0] trial;
        dv_rem_step = dv_rem_reg;
        dv_quo_step = dv_quo_reg;
        trial       = '0;
        for (int i = 0; i < DIV_STEP; i++) begin
            trial       = {dv_rem_step, dv_quo_step[DIV_W-1]};
            dv_quo_step = {dv_quo_step[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, tick_eff}) begin
                dv_rem_step    = TICK_W'(trial - {1'b0, tick_eff});
                dv_quo_step[0] = 1'b1;
            end else begin
                dv_rem_step = trial[TICK_W-1:0];
            end
        end
    end

    // floored quotient of the derivative term
    assign dq = dv_neg_reg ?
                -($signed(DQ_W'(dv_quo_reg)) + $signed(DQ_W'(dv_rem_reg != '0))) :
                $signed(DQ_W'(dv_quo_reg));

    // total and drive
    assign total_sum   = PROD_W'(acc_reg) + PROD_W'(dq);
    assign total_sat   = sat32(total_sum);
    assign total_whole = total_sat[TOTAL_W-2:8];
    assign drive_val   = total_sat[TOTAL_W-1] ? '0 :
                         (total_whole > (TOTAL_W-9)'(DRIVE_LIM)) ? DRIVE_W'(DRIVE_LIM) :
                         total_whole[DRIVE_W-1:0];

    // next state of sequencer and datapath
    always_comb begin
        step_next      = hold ? step_reg : (ctl.jump ? ctl.target : step_reg + 1'b1);
        sp_num_next    = sp_num_reg;
        ms_num_next    = ms_num_reg;
        q_next         = q_reg;
        prod_next      = prod_reg;
        sp_next        = sp_reg;
        meas_next      = meas_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        last_err_next  = last_err_reg;
        integral_next  = integral_reg;
        acc_next       = acc_reg;
        dv_neg_next    = dv_neg_reg;
        out_drive_next = out_drive_reg;
        out_total_next = out_total_reg;
        out_sp_next    = out_sp_reg;
        out_meas_next  = out_meas_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        // divider iterates on its own once started
        if (dv_cnt_reg != '0) begin
            dv_cnt_next = dv_cnt_reg - 1'b1;
            dv_quo_next = dv_quo_step;
            dv_rem_next = dv_rem_step;
        end else begin
            dv_cnt_next = dv_cnt_reg;
            dv_quo_next = dv_quo_reg;
            dv_rem_next = dv_rem_reg;
        end

        if (!hold) begin
            case (ctl.op)
                OP_LOAD: begin
                    sp_num_next = NUM_W'(code_cut) * NUM_W'(SP_SCALE);
                    ms_num_next = NUM_W'(echo_sat) * NUM_W'(MS_SCALE);
                end
                OP_MUL_SP_RCP, OP_MUL_MS_RCP, OP_MUL_P, OP_MUL_I: begin
                    prod_next = $signed(mul_full[PROD_W-1:0]);
                end
                OP_MUL_SP_BACK, OP_MUL_MS_BACK: begin
                    q_next    = prod_reg[RCP_SHIFT +: Q_W];
                    prod_next = $signed(mul_full[PROD_W-1:0]);
                end
                OP_SP_FIX: begin
                    sp_next = sp_clamped;
                end
                OP_MS_FIX: begin
                    meas_next = meas_sat;
                end
                OP_ERR: begin
                    err_next      = err_val;
                    diff_next     = diff_val;
                    last_err_next = err_val;
                end
                OP_P_ACC: begin
                    acc_next  = ACC_W'(prod_reg >>> GAIN_FRAC);
                    prod_next = $signed(mul_full[PROD_W-1:0]);
                end
                OP_INTEG: begin
                    integral_next = sat32(integ_sum);
                    prod_next     = $signed(mul_full[PROD_W-1:0]);
                end
                OP_D_START: begin
                    acc_next    = acc_reg + ACC_W'(integral_reg);
                    dv_quo_next = div_mag;
                    dv_rem_next = '0;
                    dv_cnt_next = DIV_CNT_W'(DIV_ITERS);
                    dv_neg_next = div_pre[DIV_W];
                end
                OP_FINISH: begin
                    m_valid_next   = 1'b1;
                    out_drive_next = drive_val;
                    out_total_next = total_sat;
                    out_sp_next    = sp_reg;
                    out_meas_next  = meas_reg;
                end
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= STEP_LOAD;
            m_valid_reg  <= 1'b0;
            integral_reg <= '0;
            last_err_reg <= '0;
            dv_cnt_reg   <= '0;
        end else begin
            step_reg     <= step_next;
            m_valid_reg  <= m_valid_next;
            integral_reg <= integral_next;
            last_err_reg <= last_err_next;
            dv_cnt_reg   <= dv_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sp_num_reg    <= sp_num_next;
        ms_num_reg    <= ms_num_next;
        q_reg         <= q_next;
        prod_reg      <= prod_next;
        sp_reg        <= sp_next;
        meas_reg      <= meas_next;
        err_reg       <= err_next;
        diff_reg      <= diff_next;
        acc_reg       <= acc_next;
        dv_quo_reg    <= dv_quo_next;
        dv_rem_reg    <= dv_rem_next;
        dv_neg_reg    <= dv_neg_next;
        out_drive_reg <= out_drive_next;
        out_total_reg <= out_total_next;
        out_sp_reg    <= out_sp_next;
        out_meas_reg  <= out_meas_next;
    end

    // result item
    assign m_valid       = m_valid_reg;
    assign m_drive       = out_drive_reg;
    assign m_pid_total   = out_total_reg;
    assign m_setpoint_cm = out_sp_reg;
    assign m_measured_cm = out_meas_reg;

endmodule

[sim/tb_top.sv]
// self-checking testbench for the ball-height pid controller with its own fixed-point predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bhpid_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 9;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int TAIL_CYCLES    = 48;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int REPORT_MAX     = 10;
    localparam int PHASE_ITEMS    = 250;

    // register indexes the block does not implement
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_FREE = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP        = '1;

    typedef struct packed {
        logic [DRIVE_W-1:0]        drive;
        logic signed [TOTAL_W-1:0] total;
        logic [SETPOINT_W-1:0]     setpoint;
        logic [MEAS_W-1:0]         measured;
    } drive_result_t;

    // dut ports; the inputs are known from time zero
    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [ADC_W-1:0]       s_adc_word    = '0;
    logic [ECHO_W-1:0]      s_echo_us     = '0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic [DRIVE_W-1:0]     m_drive;
    logic signed [TOTAL_W-1:0] m_pid_total;
    logic [SETPOINT_W-1:0]  m_setpoint_cm;
    logic [MEAS_W-1:0]      m_measured_cm;

    // predictor copy of the configuration and the controller state
    logic [GAIN_W-1:0]      pid_gain_p    = RST_GAIN_PROP;
    logic [GAIN_W-1:0]      pid_gain_i    = RST_GAIN_INTEG;
    logic [GAIN_W-1:0]      pid_gain_d    = RST_GAIN_DERIV;
    logic [TICK_W-1:0]      pid_tick_ms   = RST_TICK_MS;
    int                     pid_integral  = 0;
    int                     pid_last_err  = 0;

    drive_result_t          expected_drive_q[$];
    drive_result_t          chk_want;

    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     holdoff_len   = 0;
    logic                   rx_hold       = 1'b0;

    int                     cycle_cnt     = 0;
    int                     items_sent    = 0;
    int                     results_seen  = 0;
    int                     mismatch_cnt  = 0;
    int                     settings_cnt  = 0;

    ball_height_pid_controller u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_adc_word    (s_adc_word),
        .s_echo_us     (s_echo_us),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive       (m_drive),
        .m_pid_total   (m_pid_total),
        .m_setpoint_cm (m_setpoint_cm),
        .m_measured_cm (m_measured_cm)
    );

    // clock
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // division rounding toward minus infinity, positive divisor
    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint clamp_s32(longint v);
        if (v > longint'(32'sh7FFF_FFFF)) begin
            return longint'(32'sh7FFF_FFFF);
        end
        if (v < -longint'(64'sh8000_0000)) begin
            return -longint'(64'sh8000_0000);
        end
        return v;
    endfunction

    // one control tick: expected outputs, updates integral and last error
    function automatic drive_result_t pid_tick(logic [ADC_W-1:0] adc, logic [ECHO_W-1:0] echo);
        logic [15:0]   swapped;
        logic [11:0]   code;
        logic [15:0]   echo_sat;
        longint        setp, meas, err, diff, tk, p_term, inc, d_term, total, drv;
        drive_result_t r;
        swapped = {adc[7:0], adc[15:8]};
        code = swapped[15:4];
        if (code > CODE_CUTOFF) begin
            code = '0;
        end
        setp = (longint'(code) * SP_SCALE) / SP_DIV;
        if (setp < SET_MIN) setp = SET_MIN;
        if (setp > SET_MAX) setp = SET_MAX;

        echo_sat = (echo < ECHO_LIMIT_US) ? echo : 16'(ECHO_LIMIT_US);
        meas = (longint'(echo_sat) * MS_SCALE) / MS_DIV;
        if (meas > MEAS_SAT) meas = MEAS_SAT;

        tk = (pid_tick_ms == '0) ? 1 : longint'(pid_tick_ms);
        err = setp - meas;
        diff = err - longint'(pid_last_err);

        p_term = floor_quot(longint'(pid_gain_p) * err, 65536);
        inc = floor_quot(longint'(pid_gain_i) * err * tk, 65536);
        pid_integral = int'(clamp_s32(longint'(pid_integral) + inc));
        d_term = floor_quot(longint'(pid_gain_d) * diff, tk * 65536);
        total = clamp_s32(p_term + longint'(pid_integral) + d_term);
        pid_last_err = int'(err);

        drv = total / 256;
        if (drv < 0) drv = 0;
        if (drv > DRIVE_LIM) drv = DRIVE_LIM;

        r.drive    = drv[DRIVE_W-1:0];
        r.total    = total[TOTAL_W-1:0];
        r.setpoint = setp[SETPOINT_W-1:0];
        r.measured = meas[MEAS_W-1:0];
        return r;
    endfunction

    // converter word carrying a 12-bit code, bytes swapped
    function automatic logic [ADC_W-1:0] adc_word_for(int unsigned code, int unsigned nib);
        logic [15:0] raw;
        raw = {code[11:0], nib[3:0]};
        return {raw[7:0], raw[15:8]};
    endfunction

    // gain drawn from the extremes, the full range or a working range
    function automatic logic [GAIN_W-1:0] rand_gain(int unsigned work_max);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom());
            default: return GAIN_W'($urandom_range(0, work_max));
        endcase
    endfunction

    // result receiver: random idling plus the long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off, counted in cycles
    initial begin
        forever begin
            wait (holdoff_len > 0);
            rx_hold <= 1'b1;
            repeat (holdoff_len) @(posedge aclk);
            rx_hold <= 1'b0;
            holdoff_len = 0;
        end
    end

    // result checker against the oldest expected item
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_drive_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX) begin
                    $display("[%0t] unexpected item: drive %0d total %0d setpoint %0d measured %0d",
                             $realtime, m_drive, m_pid_total, m_setpoint_cm, m_measured_cm);
                end
            end else begin
                chk_want = expected_drive_q.pop_front();
                if (m_drive !== chk_want.drive || m_pid_total !== chk_want.total ||
                    m_setpoint_cm !== chk_want.setpoint ||
                    m_measured_cm !== chk_want.measured) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX) begin
                        $display("[%0t] mismatch on item %0d", $realtime, results_seen);
                        $display("    drive    exp %0d got %0d", chk_want.drive, m_drive);
                        $display("    total    exp %0d got %0d", chk_want.total, m_pid_total);
                        $display("    setpoint exp %0d got %0d", chk_want.setpoint, m_setpoint_cm);
                        $display("    measured exp %0d got %0d", chk_want.measured, m_measured_cm);
                    end
                end
            end
        end
    end

    // run limit
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("run limit of %0d cycles reached, %0d items still expected",
                 CYCLE_LIMIT, expected_drive_q.size());
        $display("FAILURE");
        $finish;
    end

    // offer one item; valid is only lowered when the sender idles
    task automatic send_item(logic [ADC_W-1:0] adc, logic [ECHO_W-1:0] echo);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_adc_word <= adc;
        s_echo_us  <= echo;
        do @(posedge aclk); while (!s_ready);
        expected_drive_q.push_back(pid_tick(adc, echo));
        items_sent++;
    endtask

    // stop offering and wait for every expected result
    task automatic wait_results_done();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_drive_q.size() != 0);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data, bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_GAIN_PROP:  pid_gain_p  = data;
            CFG_GAIN_INTEG: pid_gain_i  = data;
            CFG_GAIN_DERIV: pid_gain_d  = data;
            CFG_TICK_MS:    pid_tick_ms = data[TICK_W-1:0];
            default: ;
        endcase
        if (last) begin
            cfg_valid <= 1'b0;
        end
    endtask

    // all four registers, only while the block is idle
    task automatic write_gains(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                               logic [31:0] tk);
        cfg_write(CFG_GAIN_PROP, gp, 1'b0);
        cfg_write(CFG_GAIN_INTEG, gi, 1'b0);
        cfg_write(CFG_GAIN_DERIV, gd, 1'b0);
        cfg_write(CFG_TICK_MS, tk, 1'b1);
        settings_cnt++;
    endtask

    // random item: most often tracking near the target, else in-range, edges and noise
    task automatic send_random_item();
        int unsigned code;
        int          e;
        logic [15:0] adc, echo;
        code = $urandom_range(0, CODE_CUTOFF);
        adc = adc_word_for(code, $urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                e = (int'(code) * 27) / 8 + int'($urandom_range(0, 400)) - 200;
                if (e < 0) e = 0;
                echo = 16'(e);
            end
            4, 5, 6: begin
                echo = 16'($urandom_range(0, ECHO_LIMIT_US));
            end
            7: begin
                adc = adc_word_for($urandom_range(CODE_CUTOFF - 5, CODE_CUTOFF + 5),
                                   $urandom_range(0, 15));
                echo = 16'($urandom_range(ECHO_LIMIT_US - 8, ECHO_LIMIT_US + 8));
            end
            default: begin
                adc = 16'($urandom_range(0, 16'hFFFF));
                echo = 16'($urandom_range(0, 16'hFFFF));
            end
        endcase
        send_item(adc, echo);
    endtask

    // reset configuration: field extremes, cutoff, setpoint clamps, echo limit
    task automatic test_reset_defaults();
        send_item(16'h0000, 16'd0);
        send_item(16'hFFFF, 16'hFFFF);
        send_item(adc_word_for(CODE_CUTOFF, 0), 16'(ECHO_LIMIT_US));
        send_item(adc_word_for(CODE_CUTOFF + 1, 15), 16'(ECHO_LIMIT_US + 1));
        send_item(adc_word_for(SP_DIV, 5), 16'(ECHO_LIMIT_US - 1));
        send_item(adc_word_for(87, 10), 16'd1);
        send_item(adc_word_for(88, 0), 16'h8000);
        send_item(adc_word_for(1500, 3), 16'd5000);
        send_item(adc_word_for(1500, 3), 16'd5000);
        send_item(adc_word_for(1200, 12), 16'd4050);
        wait_results_done();
    endtask

    // zero interval treated as one, top of the field, data bits above the field
    task automatic test_zero_interval();
        write_gains(RST_GAIN_PROP, RST_GAIN_INTEG, 32'h0004_0000, 32'd0);
        send_item(adc_word_for(1000, 7), 16'd1000);
        send_item(adc_word_for(400, 1), 16'd3000);
        wait_results_done();
        write_gains(RST_GAIN_PROP, 32'd4000, RST_GAIN_DERIV, 32'd1023);
        send_item(adc_word_for(1700, 9), 16'd200);
        wait_results_done();
        write_gains(RST_GAIN_PROP, RST_GAIN_INTEG, RST_GAIN_DERIV, 32'hFFFF_FC01);
        send_item(adc_word_for(300, 2), 16'd12000);
        wait_results_done();
    endtask

    // largest gains and an interval of 1000: integral and total saturate both ways, then zero gains
    task automatic test_saturation();
        write_gains('1, '1, '1, 32'd1000);
        repeat (3) send_item(adc_word_for(SP_DIV, 0), 16'd0);
        repeat (3) send_item(adc_word_for(0, 0), 16'(ECHO_LIMIT_US));
        wait_results_done();
        write_gains('0, '0, '0, 32'd1);
        send_item(adc_word_for(900, 4), 16'd7000);
        wait_results_done();
    endtask

    // writes to unimplemented indexes leave the gains alone
    task automatic test_unknown_register();
        cfg_write(CFG_GAIN_PROP, RST_GAIN_PROP, 1'b0);
        cfg_write(CFG_GAIN_INTEG, RST_GAIN_INTEG, 1'b0);
        cfg_write(CFG_GAIN_DERIV, RST_GAIN_DERIV, 1'b0);
        cfg_write(CFG_TICK_MS, 32'(RST_TICK_MS), 1'b0);
        settings_cnt++;
        cfg_write(CFG_IDX_FIRST_FREE, '1, 1'b0);
        cfg_write(CFG_IDX_TOP, 32'h0000_0001, 1'b1);
        send_item(adc_word_for(1100, 6), 16'd2500);
        send_item(adc_word_for(600, 8), 16'd9000);
        wait_results_done();
    endtask

    // random items under a sequence of random gain settings
    task automatic test_random_traffic(int n_items, int snd_pct, int rcv_pct);
        int left, chunk;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        left = n_items;
        while (left > 0) begin
            chunk = $urandom_range(30, 70);
            if (chunk > left) chunk = left;
            case ($urandom_range(0, 5))
                0:       write_gains(rand_gain(1 << 21), rand_gain(4096), rand_gain(1 << 20),
                                     32'($urandom_range(0, 3) == 0 ? 0 : 1023));
                1:       write_gains(rand_gain(1 << 21), rand_gain(4096), rand_gain(1 << 20),
                                     32'($urandom_range(0, 1) == 0 ? 1 : 1000));
                default: write_gains(rand_gain(1 << 21), rand_gain(4096), rand_gain(1 << 20),
                                     32'($urandom_range(1, 1000)));
            endcase
            repeat (chunk) send_random_item();
            wait_results_done();
            left -= chunk;
        end
    endtask

    // receiver holds off while items keep coming, then the sender waits for each batch
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holdoff_len = HOLDOFF_CYCLES;
        repeat (12) send_random_item();
        wait_results_done();
        repeat (3) begin
            repeat (4) send_random_item();
            wait_results_done();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 67;
        test_reset_defaults();
        test_zero_interval();
        test_saturation();
        test_unknown_register();

        test_random_traffic(PHASE_ITEMS, 28, 67);
        test_random_traffic(PHASE_ITEMS, 67, 28);
        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_output_stall();

        s_valid <= 1'b0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_drive_q.size() != 0) begin
            $display("%0d expected items never arrived", expected_drive_q.size());
            mismatch_cnt += expected_drive_q.size();
        end

        $display("sent %0d items under %0d gain settings, checked %0d results, %0d mismatches",
                 items_sent, settings_cnt, results_seen, mismatch_cnt);
        $display("covered clamps, cutoff, zero interval, saturation, unused indexes, stalls");
        if (mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
